[src/calendar_clock_prescaled_unit_assert.svh]
// assertion macros for the calendar clock unit checker
// no dependencies; taken in by the checker file only
`ifndef CALENDAR_CLOCK_PRESCALED_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_PRESCALED_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define CCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar unit check failed");

// next-cycle implication, held off during reset
`define CCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar unit check failed");

`endif

[src/ccp_pkg.sv]
// shared types and constants for the calendar clock unit
// used by the controller, the datapath and the top level
`default_nettype none

package ccp_pkg;

  // field widths of the transaction payloads
  localparam int MINUTE_W = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 15;
  localparam int TICK_W   = 16;
  localparam int DELTA_W  = 16;
  localparam int RESID_W  = 17;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_MINUTE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EVENTS_ENABLE    = 1'd1;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK_FWD  = 2'd0,
    REQ_TICK_BACK = 2'd1,
    REQ_STEP      = 2'd2,
    REQ_SET       = 2'd3
  } req_t;

  // season codes and month boundaries
  localparam logic [1:0] SEASON_COLD = 2'd0;
  localparam logic [1:0] SEASON_MILD = 2'd1;
  localparam logic [1:0] SEASON_WARM = 2'd2;
  localparam logic [1:0] SEASON_COOL = 2'd3;
  localparam int SPRING_FIRST_MONTH = 3;
  localparam int SUMMER_FIRST_MONTH = 5;
  localparam int AUTUMN_FIRST_MONTH = 8;
  localparam int WINTER_FIRST_MONTH = 11;

  // night window and announced hours
  localparam int DAWN_HOUR     = 5;
  localparam int DUSK_HOUR     = 20;
  localparam int ANNOUNCE_H0   = 0;
  localparam int ANNOUNCE_H1   = 6;
  localparam int ANNOUNCE_H2   = 12;
  localparam int ANNOUNCE_H3   = 18;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic advance;
    logic capture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } status_t;

endpackage

`default_nettype wire

[src/ccp_ctrl.sv]
// sequencer for the calendar clock unit: item intake, minute stepping, result hand-off
// depends on ccp_pkg
`default_nettype none

module ccp_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  ccp_pkg::status_t status,
  output ccp_pkg::cmd_t    cmd
);
  import ccp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register may be refilled when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  // command decode
  always_comb begin
    cmd.start   = (state_r == ST_IDLE) && in_valid;
    cmd.advance = (state_r == ST_RUN) && !status.done;
    cmd.capture = (((state_r == ST_RUN) && status.done) || (state_r == ST_HOLD)) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.done) state_nxt = cmd.capture ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (cmd.capture) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.capture) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/ccp_datapath.sv]
// calendar counters, tick residual, step count, config registers and result register
// depends on ccp_pkg
`default_nettype none

module ccp_datapath #(
  parameter int MINUTES_PER_HOUR = 60,
  parameter int HOURS_PER_DAY    = 24,
  parameter int DAYS_PER_MONTH   = 30,
  parameter int MONTHS_PER_YEAR  = 12
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [ccp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire  [ccp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  ccp_pkg::req_t                       req_type,
  input  wire  [ccp_pkg::TICK_W-1:0]          tick_count,
  input  wire  [ccp_pkg::DELTA_W-1:0]         minute_delta,
  input  wire  [ccp_pkg::YEAR_W-1:0]          load_year,
  input  wire  [ccp_pkg::MONTH_W-1:0]         load_month,
  input  wire  [ccp_pkg::DAY_W-1:0]           load_day,
  input  wire  [ccp_pkg::HOUR_W-1:0]          load_hour,
  input  wire  [ccp_pkg::MINUTE_W-1:0]        load_minute,
  input  ccp_pkg::cmd_t                       cmd,
  output ccp_pkg::status_t                    status,
  output logic [ccp_pkg::MINUTE_W-1:0]        cur_minute,
  output logic [ccp_pkg::HOUR_W-1:0]          cur_hour,
  output logic [ccp_pkg::DAY_W-1:0]           cur_day,
  output logic [ccp_pkg::MONTH_W-1:0]         cur_month,
  output logic [ccp_pkg::YEAR_W-1:0]          cur_year,
  output logic                                is_dark,
  output logic [1:0]                          season_code,
  output logic                                sun_changed,
  output logic                                hour_announced
);
  import ccp_pkg::*;

  // counters are wide enough for both the loaded field and the parameter range
  localparam int MIN_W = ($clog2(MINUTES_PER_HOUR) > MINUTE_W) ? $clog2(MINUTES_PER_HOUR)
                                                               : MINUTE_W;
  localparam int HR_W  = ($clog2(HOURS_PER_DAY) > HOUR_W) ? $clog2(HOURS_PER_DAY) : HOUR_W;
  localparam int DY_W  = ($clog2(DAYS_PER_MONTH) > DAY_W) ? $clog2(DAYS_PER_MONTH) : DAY_W;
  localparam int MO_W  = ($clog2(MONTHS_PER_YEAR) > MONTH_W) ? $clog2(MONTHS_PER_YEAR)
                                                             : MONTH_W;
  localparam logic [MIN_W-1:0]  MIN_TOP  = MIN_W'(MINUTES_PER_HOUR - 1);
  localparam logic [HR_W-1:0]   HR_TOP   = HR_W'(HOURS_PER_DAY - 1);
  localparam logic [DY_W-1:0]   DY_TOP   = DY_W'(DAYS_PER_MONTH - 1);
  localparam logic [MO_W-1:0]   MO_TOP   = MO_W'(MONTHS_PER_YEAR - 1);
  localparam logic [YEAR_W-1:0] YEAR_TOP = '1;

  function automatic logic dark_of(input logic [HR_W-1:0] h);
    return (h < HR_W'(DAWN_HOUR)) || (h >= HR_W'(DUSK_HOUR));
  endfunction

  function automatic logic [1:0] season_of(input logic [MO_W-1:0] m);
    logic [1:0] s;
    if (m < MO_W'(SPRING_FIRST_MONTH)) s = SEASON_COLD;
    else if (m < MO_W'(SUMMER_FIRST_MONTH)) s = SEASON_MILD;
    else if (m < MO_W'(AUTUMN_FIRST_MONTH)) s = SEASON_WARM;
    else if (m < MO_W'(WINTER_FIRST_MONTH)) s = SEASON_COOL;
    else s = SEASON_COLD;
    return s;
  endfunction

  // configuration
  logic [TICK_W-1:0] ticks_per_minute_r;
  logic              events_enable_r;

  // calendar and sequencing state
  logic [MIN_W-1:0]   minute_r, minute_nxt;
  logic [HR_W-1:0]    hour_r, hour_nxt;
  logic [DY_W-1:0]    day_r, day_nxt;
  logic [MO_W-1:0]    month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [RESID_W-1:0] resid_r, resid_nxt;
  logic [DELTA_W-1:0] count_r, count_nxt;
  req_t               mode_r, mode_nxt;
  logic               back_r, back_nxt;
  logic               sun_r, sun_nxt;
  logic               ann_r, ann_nxt;

  // result register
  logic [MINUTE_W-1:0] out_minute_r;
  logic [HOUR_W-1:0]   out_hour_r;
  logic [DAY_W-1:0]    out_day_r;
  logic [MONTH_W-1:0]  out_month_r;
  logic [YEAR_W-1:0]   out_year_r;
  logic                out_dark_r;
  logic [1:0]          out_season_r;
  logic                out_sun_r;
  logic                out_ann_r;

  logic [RESID_W-1:0] period;
  logic               at_top, at_zero, hour_carry;
  logic [MIN_W-1:0]   f_minute, b_minute;
  logic [HR_W-1:0]    f_hour, b_hour;
  logic [DY_W-1:0]    f_day, b_day;
  logic [MO_W-1:0]    f_month, b_month;
  logic [YEAR_W-1:0]  f_year, b_year;

  // zero prescale counts as one
  assign period = (ticks_per_minute_r == '0) ? RESID_W'(1) : {1'b0, ticks_per_minute_r};

  // item finished
  always_comb begin
    case (mode_r)
      REQ_TICK_FWD, REQ_TICK_BACK: status.done = (resid_r < period);
      REQ_STEP:                    status.done = (count_r == '0);
      REQ_SET:                     status.done = 1'b1;
      default:                     status.done = 1'b1;
    endcase
  end

  // one minute forward, holding at the last minute of the last year
  always_comb begin
    at_top = (year_r == YEAR_TOP) && (month_r >= MO_TOP) && (day_r >= DY_TOP) &&
             (hour_r >= HR_TOP) && (minute_r >= MIN_TOP);
    f_minute   = minute_r;
    f_hour     = hour_r;
    f_day      = day_r;
    f_month    = month_r;
    f_year     = year_r;
    hour_carry = 1'b0;
    if (!at_top) begin
      if (minute_r < MIN_TOP) begin
        f_minute = minute_r + 1'b1;
      end else begin
        f_minute   = '0;
        hour_carry = 1'b1;
        if (hour_r < HR_TOP) begin
          f_hour = hour_r + 1'b1;
        end else begin
          f_hour = '0;
          if (day_r < DY_TOP) begin
            f_day = day_r + 1'b1;
          end else begin
            f_day = '0;
            if (month_r < MO_TOP) begin
              f_month = month_r + 1'b1;
            end else begin
              f_month = '0;
              f_year  = year_r + 1'b1;
            end
          end
        end
      end
    end
  end

  // one minute back, holding at the all zero date
  always_comb begin
    at_zero = (minute_r == '0) && (hour_r == '0) && (day_r == '0) &&
              (month_r == '0) && (year_r == '0);
    b_minute = minute_r;
    b_hour   = hour_r;
    b_day    = day_r;
    b_month  = month_r;
    b_year   = year_r;
    if (!at_zero) begin
      if (minute_r != '0) begin
        b_minute = minute_r - 1'b1;
      end else begin
        b_minute = MIN_TOP;
        if (hour_r != '0) begin
          b_hour = hour_r - 1'b1;
        end else begin
          b_hour = HR_TOP;
          if (day_r != '0) begin
            b_day = day_r - 1'b1;
          end else begin
            b_day = DY_TOP;
            if (month_r != '0) begin
              b_month = month_r - 1'b1;
            end else begin
              b_month = MO_TOP;
              b_year  = year_r - 1'b1;
            end
          end
        end
      end
    end
  end

  // next state of the counters
  always_comb begin
    minute_nxt = minute_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    resid_nxt  = resid_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    back_nxt   = back_r;
    sun_nxt    = sun_r;
    ann_nxt    = ann_r;
    if (cmd.start) begin
      mode_nxt = req_type;
      sun_nxt  = 1'b0;
      ann_nxt  = 1'b0;
      case (req_type)
        REQ_TICK_FWD, REQ_TICK_BACK: begin
          resid_nxt = resid_r + RESID_W'(tick_count);
          back_nxt  = (req_type == REQ_TICK_BACK);
        end
        REQ_STEP: begin
          back_nxt  = minute_delta[DELTA_W-1];
          count_nxt = minute_delta[DELTA_W-1] ? (DELTA_W'(0) - minute_delta) : minute_delta;
        end
        REQ_SET: begin
          year_nxt   = load_year;
          month_nxt  = MO_W'(load_month);
          day_nxt    = DY_W'(load_day);
          hour_nxt   = HR_W'(load_hour);
          minute_nxt = MIN_W'(load_minute);
          resid_nxt  = '0;
        end
        default: mode_nxt = req_type;
      endcase
    end else if (cmd.advance) begin
      if (mode_r == REQ_STEP) count_nxt = count_r - 1'b1;
      else resid_nxt = resid_r - period;
      if (back_r) begin
        minute_nxt = b_minute;
        hour_nxt   = b_hour;
        day_nxt    = b_day;
        month_nxt  = b_month;
        year_nxt   = b_year;
      end else begin
        minute_nxt = f_minute;
        hour_nxt   = f_hour;
        day_nxt    = f_day;
        month_nxt  = f_month;
        year_nxt   = f_year;
        // event flags on forward hour carries
        if (hour_carry && events_enable_r) begin
          if ((f_hour == HR_W'(ANNOUNCE_H0)) || (f_hour == HR_W'(ANNOUNCE_H1)) ||
              (f_hour == HR_W'(ANNOUNCE_H2)) || (f_hour == HR_W'(ANNOUNCE_H3)))
            ann_nxt = 1'b1;
          if (dark_of(hour_r) != dark_of(f_hour)) sun_nxt = 1'b1;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_minute_r <= TICK_W'(1);
      events_enable_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TICKS_PER_MINUTE: ticks_per_minute_r <= cfg_wdata[TICK_W-1:0];
        REG_EVENTS_ENABLE:    events_enable_r    <= cfg_wdata[0];
        default:              events_enable_r    <= events_enable_r;
      endcase
    end
  end

  // calendar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_r <= '0;
      hour_r   <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      resid_r  <= '0;
      count_r  <= '0;
      mode_r   <= REQ_SET;
      back_r   <= 1'b0;
      sun_r    <= 1'b0;
      ann_r    <= 1'b0;
    end else begin
      minute_r <= minute_nxt;
      hour_r   <= hour_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      resid_r  <= resid_nxt;
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      back_r   <= back_nxt;
      sun_r    <= sun_nxt;
      ann_r    <= ann_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_minute_r <= minute_r[MINUTE_W-1:0];
      out_hour_r   <= hour_r[HOUR_W-1:0];
      out_day_r    <= day_r[DAY_W-1:0];
      out_month_r  <= month_r[MONTH_W-1:0];
      out_year_r   <= year_r;
      out_dark_r   <= dark_of(hour_r);
      out_season_r <= season_of(month_r);
      out_sun_r    <= sun_r;
      out_ann_r    <= ann_r;
    end
  end

  assign cur_minute     = out_minute_r;
  assign cur_hour       = out_hour_r;
  assign cur_day        = out_day_r;
  assign cur_month      = out_month_r;
  assign cur_year       = out_year_r;
  assign is_dark        = out_dark_r;
  assign season_code    = out_season_r;
  assign sun_changed    = out_sun_r;
  assign hour_announced = out_ann_r;

endmodule

`default_nettype wire

[src/calendar_clock_prescaled_unit.sv]
// Calendar counter with tick prescaler. A transaction is taken in, the calendar
// is stepped one minute at a time, and the result is loaded into the result
// register once that register is free: a set item takes no steps, a step item
// |minute_delta| steps, and a tick item floor((residual + tick_count) / period)
// steps, where period is ticks_per_minute (0 counts as 1). The steps come from
// the single minute-stepping datapath, which in a tick item also removes one
// prescale period from the residual at each step. One transaction is worked
// on at a time; the next one is taken while the last result still waits in
// the output register.
// depends on ccp_pkg, ccp_ctrl and ccp_datapath
`default_nettype none

module calendar_clock_prescaled_unit #(
  parameter int MINUTES_PER_HOUR = 60,
  parameter int HOURS_PER_DAY    = 24,
  parameter int DAYS_PER_MONTH   = 30,
  parameter int MONTHS_PER_YEAR  = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [ccp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [ccp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       in_req_type,
  input  wire  [ccp_pkg::TICK_W-1:0]       in_tick_count,
  input  wire  [ccp_pkg::DELTA_W-1:0]      in_minute_delta,
  input  wire  [ccp_pkg::YEAR_W-1:0]       in_load_year,
  input  wire  [ccp_pkg::MONTH_W-1:0]      in_load_month,
  input  wire  [ccp_pkg::DAY_W-1:0]        in_load_day,
  input  wire  [ccp_pkg::HOUR_W-1:0]       in_load_hour,
  input  wire  [ccp_pkg::MINUTE_W-1:0]     in_load_minute,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [ccp_pkg::MINUTE_W-1:0]     out_cur_minute,
  output logic [ccp_pkg::HOUR_W-1:0]       out_cur_hour,
  output logic [ccp_pkg::DAY_W-1:0]        out_cur_day,
  output logic [ccp_pkg::MONTH_W-1:0]      out_cur_month,
  output logic [ccp_pkg::YEAR_W-1:0]       out_cur_year,
  output logic                             out_is_dark,
  output logic [1:0]                       out_season_code,
  output logic                             out_sun_changed,
  output logic                             out_hour_announced
);
  import ccp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  ccp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // counters and result register
  ccp_datapath #(
    .MINUTES_PER_HOUR (MINUTES_PER_HOUR),
    .HOURS_PER_DAY    (HOURS_PER_DAY),
    .DAYS_PER_MONTH   (DAYS_PER_MONTH),
    .MONTHS_PER_YEAR  (MONTHS_PER_YEAR)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .req_type       (req_t'(in_req_type)),
    .tick_count     (in_tick_count),
    .minute_delta   (in_minute_delta),
    .load_year      (in_load_year),
    .load_month     (in_load_month),
    .load_day       (in_load_day),
    .load_hour      (in_load_hour),
    .load_minute    (in_load_minute),
    .cmd            (cmd),
    .status         (status),
    .cur_minute     (out_cur_minute),
    .cur_hour       (out_cur_hour),
    .cur_day        (out_cur_day),
    .cur_month      (out_cur_month),
    .cur_year       (out_cur_year),
    .is_dark        (out_is_dark),
    .season_code    (out_season_code),
    .sun_changed    (out_sun_changed),
    .hour_announced (out_hour_announced)
  );

endmodule

`default_nettype wire

[src/ccp_checker.sv]
// port-level checks for the calendar clock unit, bound to the top level
// depends on calendar_clock_prescaled_unit_assert.svh
`default_nettype none
`include "calendar_clock_prescaled_unit_assert.svh"

module ccp_checker #(
  parameter int HOURS_PER_DAY   = 24,
  parameter int MONTHS_PER_YEAR = 12
) (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [5:0]  out_cur_minute,
  input wire [4:0]  out_cur_hour,
  input wire [4:0]  out_cur_day,
  input wire [3:0]  out_cur_month,
  input wire [14:0] out_cur_year,
  input wire        out_is_dark,
  input wire [1:0]  out_season_code,
  input wire        out_sun_changed,
  input wire        out_hour_announced
);

  // a stalled result transaction stays offered
  `CCP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // a stalled result transaction keeps its payload
  `CCP_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    ($stable({out_cur_minute, out_cur_hour, out_cur_day, out_cur_month, out_cur_year,
              out_is_dark, out_season_code, out_sun_changed, out_hour_announced})))

  // night flag follows the reported hour
  if (HOURS_PER_DAY <= 32) begin : g_dark
    `CCP_ASSERT_IMP(a_dark, clk, rst_n, out_valid,
      (out_is_dark == ((out_cur_hour < 5'd5) || (out_cur_hour >= 5'd20))))
  end

  // season follows the reported month
  if (MONTHS_PER_YEAR <= 16) begin : g_season
    `CCP_ASSERT_IMP(a_season, clk, rst_n, out_valid,
      ((out_cur_month < 4'd3 && out_season_code == 2'd0) ||
       (out_cur_month >= 4'd3 && out_cur_month < 4'd5 && out_season_code == 2'd1) ||
       (out_cur_month >= 4'd5 && out_cur_month < 4'd8 && out_season_code == 2'd2) ||
       (out_cur_month >= 4'd8 && out_cur_month < 4'd11 && out_season_code == 2'd3) ||
       (out_cur_month >= 4'd11 && out_season_code == 2'd0)))
  end

endmodule

bind calendar_clock_prescaled_unit ccp_checker #(
  .HOURS_PER_DAY   (HOURS_PER_DAY),
  .MONTHS_PER_YEAR (MONTHS_PER_YEAR)
) u_ccp_checker (.*);

`default_nettype wire

[tb/calendar_clock_prescaled_checker.sv]
// result checker for calendar_clock_prescaled_unit: follows every request transaction,
// predicts the resulting date and flags, and compares each result transaction in order
// depends on ccp_pkg
`timescale 1ns / 100ps

module calendar_clock_prescaled_checker #(
  parameter int MINUTES_PER_HOUR = 60,
  parameter int HOURS_PER_DAY    = 24,
  parameter int DAYS_PER_MONTH   = 30,
  parameter int MONTHS_PER_YEAR  = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [ccp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [ccp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  wire  [1:0]                       in_req_type,
  input  wire  [ccp_pkg::TICK_W-1:0]       in_tick_count,
  input  wire  [ccp_pkg::DELTA_W-1:0]      in_minute_delta,
  input  wire  [ccp_pkg::YEAR_W-1:0]       in_load_year,
  input  wire  [ccp_pkg::MONTH_W-1:0]      in_load_month,
  input  wire  [ccp_pkg::DAY_W-1:0]        in_load_day,
  input  wire  [ccp_pkg::HOUR_W-1:0]       in_load_hour,
  input  wire  [ccp_pkg::MINUTE_W-1:0]     in_load_minute,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  wire  [ccp_pkg::MINUTE_W-1:0]     out_cur_minute,
  input  wire  [ccp_pkg::HOUR_W-1:0]       out_cur_hour,
  input  wire  [ccp_pkg::DAY_W-1:0]        out_cur_day,
  input  wire  [ccp_pkg::MONTH_W-1:0]      out_cur_month,
  input  wire  [ccp_pkg::YEAR_W-1:0]       out_cur_year,
  input  wire                              out_is_dark,
  input  wire  [1:0]                       out_season_code,
  input  wire                              out_sun_changed,
  input  wire                              out_hour_announced,
  output int                               fail_count,
  output int                               pending
);
  import ccp_pkg::*;

  localparam int unsigned YEAR_MAX = (1 << YEAR_W) - 1;

  // one predicted result transaction
  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic                dark;
    logic [1:0]          season;
    logic                sun;
    logic                announce;
  } date_report_t;

  // calendar state as the block should hold it
  int unsigned minute_now, hour_now, day_now, month_now, year_now;
  int unsigned tick_residual;
  int unsigned ticks_per_min;
  bit          events_on;
  bit          sun_seen, announce_seen;

  date_report_t due_dates[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  function automatic bit dark_hour(int unsigned h);
    return (h < DAWN_HOUR) || (h >= DUSK_HOUR);
  endfunction

  function automatic logic [1:0] season_for(int unsigned m);
    if (m < SPRING_FIRST_MONTH) return SEASON_COLD;
    if (m < SUMMER_FIRST_MONTH) return SEASON_MILD;
    if (m < AUTUMN_FIRST_MONTH) return SEASON_WARM;
    if (m < WINTER_FIRST_MONTH) return SEASON_COOL;
    return SEASON_COLD;
  endfunction

  // one minute on, holding at the last minute of the last year
  function automatic void minute_forward();
    bit was_night;
    if (year_now >= YEAR_MAX && month_now >= MONTHS_PER_YEAR - 1 &&
        day_now >= DAYS_PER_MONTH - 1 && hour_now >= HOURS_PER_DAY - 1 &&
        minute_now >= MINUTES_PER_HOUR - 1)
      return;
    if (minute_now < MINUTES_PER_HOUR - 1) begin
      minute_now++;
      return;
    end
    minute_now = 0;
    was_night  = dark_hour(hour_now);
    if (hour_now < HOURS_PER_DAY - 1) begin
      hour_now++;
    end else begin
      hour_now = 0;
      if (day_now < DAYS_PER_MONTH - 1) begin
        day_now++;
      end else begin
        day_now = 0;
        if (month_now < MONTHS_PER_YEAR - 1) begin
          month_now++;
        end else begin
          month_now = 0;
          year_now++;
        end
      end
    end
    // flags only come from forward hour carries
    if (events_on) begin
      if (hour_now == ANNOUNCE_H0 || hour_now == ANNOUNCE_H1 ||
          hour_now == ANNOUNCE_H2 || hour_now == ANNOUNCE_H3)
        announce_seen = 1'b1;
      if (was_night != dark_hour(hour_now)) sun_seen = 1'b1;
    end
  endfunction

  // one minute back, stopping at the all zero date
  function automatic void minute_back();
    if (minute_now == 0 && hour_now == 0 && day_now == 0 && month_now == 0 &&
        year_now == 0)
      return;
    if (minute_now > 0) begin
      minute_now--;
      return;
    end
    minute_now = MINUTES_PER_HOUR - 1;
    if (hour_now > 0) begin
      hour_now--;
      return;
    end
    hour_now = HOURS_PER_DAY - 1;
    if (day_now > 0) begin
      day_now--;
      return;
    end
    day_now = DAYS_PER_MONTH - 1;
    if (month_now > 0) begin
      month_now--;
      return;
    end
    month_now = MONTHS_PER_YEAR - 1;
    year_now--;
  endfunction

  // apply one request transaction and build the result it must give
  function automatic date_report_t apply_request(
    req_t                 kind,
    logic [TICK_W-1:0]    ticks,
    logic [DELTA_W-1:0]   delta,
    logic [YEAR_W-1:0]    y,
    logic [MONTH_W-1:0]   mo,
    logic [DAY_W-1:0]     d,
    logic [HOUR_W-1:0]    h,
    logic [MINUTE_W-1:0]  mi
  );
    int unsigned  period;
    int unsigned  moves;
    int           span;
    date_report_t r;
    sun_seen      = 1'b0;
    announce_seen = 1'b0;
    case (kind)
      REQ_TICK_FWD, REQ_TICK_BACK: begin
        period        = (ticks_per_min == 0) ? 1 : ticks_per_min;
        tick_residual = tick_residual + ticks;
        moves         = tick_residual / period;
        tick_residual = tick_residual % period;
        repeat (moves) begin
          if (kind == REQ_TICK_BACK) minute_back();
          else minute_forward();
        end
      end
      REQ_STEP: begin
        span = int'($signed(delta));
        if (span < 0) begin
          repeat (-span) minute_back();
        end else begin
          repeat (span) minute_forward();
        end
      end
      default: begin
        year_now      = y;
        month_now     = mo;
        day_now       = d;
        hour_now      = h;
        minute_now    = mi;
        tick_residual = 0;
      end
    endcase
    r.minute   = MINUTE_W'(minute_now);
    r.hour     = HOUR_W'(hour_now);
    r.day      = DAY_W'(day_now);
    r.month    = MONTH_W'(month_now);
    r.year     = YEAR_W'(year_now);
    r.dark     = dark_hour(hour_now);
    r.season   = season_for(month_now);
    r.sun      = sun_seen;
    r.announce = announce_seen;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // sample both channels and the register port at each edge
  always @(posedge clk) begin : watch
    date_report_t want;
    if (!rst_n) begin
      minute_now    = 0;
      hour_now      = 0;
      day_now       = 0;
      month_now     = 0;
      year_now      = 0;
      tick_residual = 0;
      ticks_per_min = 1;
      events_on     = 1'b0;
      due_dates.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        if (cfg_addr == REG_TICKS_PER_MINUTE) ticks_per_min = cfg_wdata;
        else if (cfg_addr == REG_EVENTS_ENABLE) events_on = cfg_wdata[0];
      end
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_dates.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatches++;
        end else begin
          want = due_dates.pop_front();
          check_field("cur_minute", 32'(want.minute), 32'(out_cur_minute));
          check_field("cur_hour", 32'(want.hour), 32'(out_cur_hour));
          check_field("cur_day", 32'(want.day), 32'(out_cur_day));
          check_field("cur_month", 32'(want.month), 32'(out_cur_month));
          check_field("cur_year", 32'(want.year), 32'(out_cur_year));
          check_field("is_dark", 32'(want.dark), 32'(out_is_dark));
          check_field("season_code", 32'(want.season), 32'(out_season_code));
          check_field("sun_changed", 32'(want.sun), 32'(out_sun_changed));
          check_field("hour_announced", 32'(want.announce), 32'(out_hour_announced));
        end
      end
      // request transaction
      if (in_valid && !in_stall) begin
        due_dates.push_back(apply_request(req_t'(in_req_type), in_tick_count,
                                          in_minute_delta, in_load_year, in_load_month,
                                          in_load_day, in_load_hour, in_load_minute));
      end
    end
    pending <= due_dates.size();
  end

endmodule

[tb/tb_calendar_clock_prescaled_unit.sv]
// top of the calendar_clock_prescaled_unit testbench: clock, reset, register set-up,
// request stimulus and result-side stalls, with the verdict from the checker
// depends on ccp_pkg, calendar_clock_prescaled_unit and calendar_clock_prescaled_checker
`timescale 1ns / 100ps

module tb_calendar_clock_prescaled_unit;
  import ccp_pkg::*;

  localparam int MIN_PER_HOUR   = 60;
  localparam int HOURS_PER_DAY  = 24;
  localparam int DAYS_PER_MONTH = 30;
  localparam int MONTHS_PER_YR  = 12;
  localparam int YEAR_MAX       = (1 << YEAR_W) - 1;
  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int HOLD_CYCLES    = 400;

  // one request transaction
  typedef struct packed {
    req_t                req;
    logic [TICK_W-1:0]   ticks;
    logic [DELTA_W-1:0]  delta;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } calendar_request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_req_type;
  logic [TICK_W-1:0]     in_tick_count;
  logic [DELTA_W-1:0]    in_minute_delta;
  logic [YEAR_W-1:0]     in_load_year;
  logic [MONTH_W-1:0]    in_load_month;
  logic [DAY_W-1:0]      in_load_day;
  logic [HOUR_W-1:0]     in_load_hour;
  logic [MINUTE_W-1:0]   in_load_minute;
  logic                  out_valid;
  logic                  out_stall;
  logic [MINUTE_W-1:0]   out_cur_minute;
  logic [HOUR_W-1:0]     out_cur_hour;
  logic [DAY_W-1:0]      out_cur_day;
  logic [MONTH_W-1:0]    out_cur_month;
  logic [YEAR_W-1:0]     out_cur_year;
  logic                  out_is_dark;
  logic [1:0]            out_season_code;
  logic                  out_sun_changed;
  logic                  out_hour_announced;

  int          fail_total;
  int          due_left;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  int          hold_asked = 0;
  int unsigned period_now = 1;
  int          big_left = 6;

  // register settings and lengths of the random phases
  int unsigned phase_period [6] = '{0, 65535, 60, 1000, 1, 7};
  bit          phase_events [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  int          phase_items  [6] = '{300, 250, 400, 300, 300, 350};

  calendar_clock_prescaled_unit #(
    .MINUTES_PER_HOUR (MIN_PER_HOUR),
    .HOURS_PER_DAY    (HOURS_PER_DAY),
    .DAYS_PER_MONTH   (DAYS_PER_MONTH),
    .MONTHS_PER_YEAR  (MONTHS_PER_YR)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tick_count      (in_tick_count),
    .in_minute_delta    (in_minute_delta),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cur_minute     (out_cur_minute),
    .out_cur_hour       (out_cur_hour),
    .out_cur_day        (out_cur_day),
    .out_cur_month      (out_cur_month),
    .out_cur_year       (out_cur_year),
    .out_is_dark        (out_is_dark),
    .out_season_code    (out_season_code),
    .out_sun_changed    (out_sun_changed),
    .out_hour_announced (out_hour_announced)
  );

  calendar_clock_prescaled_checker #(
    .MINUTES_PER_HOUR (MIN_PER_HOUR),
    .HOURS_PER_DAY    (HOURS_PER_DAY),
    .DAYS_PER_MONTH   (DAYS_PER_MONTH),
    .MONTHS_PER_YEAR  (MONTHS_PER_YR)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tick_count      (in_tick_count),
    .in_minute_delta    (in_minute_delta),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cur_minute     (out_cur_minute),
    .out_cur_hour       (out_cur_hour),
    .out_cur_day        (out_cur_day),
    .out_cur_month      (out_cur_month),
    .out_cur_year       (out_cur_year),
    .out_is_dark        (out_is_dark),
    .out_season_code    (out_season_code),
    .out_sun_changed    (out_sun_changed),
    .out_hour_announced (out_hour_announced),
    .fail_count         (fail_total),
    .pending            (due_left)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // request with every field filled with noise
  function automatic calendar_request_t noise_request(req_t kind);
    calendar_request_t c;
    c.req    = kind;
    c.ticks  = TICK_W'($urandom);
    c.delta  = DELTA_W'($urandom);
    c.year   = YEAR_W'($urandom);
    c.month  = MONTH_W'($urandom);
    c.day    = DAY_W'($urandom);
    c.hour   = HOUR_W'($urandom);
    c.minute = MINUTE_W'($urandom);
    return c;
  endfunction

  // value near the top of a counter, else anywhere up to the top, sometimes anywhere in the field
  function automatic int unsigned near_top(int unsigned top, int width);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, (1 << width) - 1);
    if (pick < 5) return top - $urandom_range(0, 2);
    return $urandom_range(0, top);
  endfunction

  // offer one transaction, valid held until it is taken
  task automatic send_request(input calendar_request_t c);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= c.req;
    in_tick_count   <= c.ticks;
    in_minute_delta <= c.delta;
    in_load_year    <= c.year;
    in_load_month   <= c.month;
    in_load_day     <= c.day;
    in_load_hour    <= c.hour;
    in_load_minute  <= c.minute;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_date(input int unsigned y, mo, d, h, mi);
    calendar_request_t c;
    c        = noise_request(REQ_SET);
    c.year   = YEAR_W'(y);
    c.month  = MONTH_W'(mo);
    c.day    = DAY_W'(d);
    c.hour   = HOUR_W'(h);
    c.minute = MINUTE_W'(mi);
    send_request(c);
  endtask

  task automatic step_minutes(input int span);
    calendar_request_t c;
    c       = noise_request(REQ_STEP);
    c.delta = DELTA_W'(span);
    send_request(c);
  endtask

  task automatic tick_clock(input req_t kind, input int unsigned count);
    calendar_request_t c;
    c       = noise_request(kind);
    c.ticks = TICK_W'(count);
    send_request(c);
  endtask

  // stop offering and wait until every result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_left != 0) @(posedge clk);
  endtask

  // both registers, written back to back while the block is idle
  task automatic configure(input int unsigned period, input bit events);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_TICKS_PER_MINUTE;
    cfg_wdata <= CFG_DATA_W'(period);
    @(posedge clk);
    cfg_addr  <= REG_EVENTS_ENABLE;
    cfg_wdata <= {15'($urandom), events};
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    period_now = (period == 0) ? 1 : period;
  endtask

  initial begin : stimulus
    int          kind;
    int          span;
    int unsigned hi;
    int unsigned amount;
    int unsigned yr;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_req_type     = REQ_TICK_FWD;
    in_tick_count   = '0;
    in_minute_delta = '0;
    in_load_year    = '0;
    in_load_month   = '0;
    in_load_day     = '0;
    in_load_hour    = '0;
    in_load_minute  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: floor at zero from reset
    tick_clock(REQ_TICK_FWD, 0);
    tick_clock(REQ_TICK_BACK, 3);
    step_minutes(-1);
    step_minutes(1);
    // year saturation at the last minute
    set_date(YEAR_MAX, MONTHS_PER_YR - 1, DAYS_PER_MONTH - 1, HOURS_PER_DAY - 1,
             MIN_PER_HOUR - 2);
    step_minutes(3);
    tick_clock(REQ_TICK_FWD, 5);
    // loads beyond the counter tops
    set_date(YEAR_MAX, 15, 31, 31, 63);
    step_minutes(1);
    set_date(100, 15, 31, 31, 63);
    step_minutes(1);
    set_date(5, 15, 31, 31, 63);
    tick_clock(REQ_TICK_BACK, 1);
    // year carry and back again
    set_date(0, MONTHS_PER_YR - 1, DAYS_PER_MONTH - 1, HOURS_PER_DAY - 1, MIN_PER_HOUR - 1);
    step_minutes(1);
    step_minutes(-1);
    // widest steps and the widest tick count
    set_date(0, 0, 0, 0, 1);
    step_minutes(-32768);
    step_minutes(32767);
    set_date(1, 2, 3, 4, 5);
    tick_clock(REQ_TICK_FWD, 65535);

    // directed with zero prescale and events on: dawn, dusk, midnight, back carry
    wait_drained();
    configure(0, 1'b1);
    set_date(9, 4, 10, DAWN_HOUR - 1, MIN_PER_HOUR - 1);
    step_minutes(1);
    set_date(9, 7, 10, DUSK_HOUR - 1, MIN_PER_HOUR - 1);
    tick_clock(REQ_TICK_FWD, 1);
    set_date(9, 7, 10, HOURS_PER_DAY - 1, MIN_PER_HOUR - 1);
    step_minutes(2);
    tick_clock(REQ_TICK_BACK, 90);

    // random phases, one register setting each
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      configure(phase_period[p], phase_events[p]);
      idle_on = (p != 4);
      for (int i = 0; i < phase_items[p]; i++) begin
        // long result hold-off while requests keep coming
        if (p == 2 && i == 100) hold_asked++;
        // sender pause until the block is empty
        if (p == 3 && i == 150) wait_drained();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          case ($urandom_range(0, 3))
            0:       yr = $urandom_range(0, YEAR_MAX);
            1:       yr = YEAR_MAX - $urandom_range(0, 1);
            2:       yr = $urandom_range(0, 2);
            default: yr = $urandom_range(0, 3000);
          endcase
          set_date(yr, near_top(MONTHS_PER_YR - 1, MONTH_W),
                   near_top(DAYS_PER_MONTH - 1, DAY_W),
                   near_top(HOURS_PER_DAY - 1, HOUR_W),
                   near_top(MIN_PER_HOUR - 1, MINUTE_W));
        end else if (kind < 50) begin
          // a handful of full range steps, the rest short
          if (big_left > 0 && $urandom_range(0, 199) == 0) begin
            big_left--;
            span = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            span = int'($urandom_range(0, 150));
            if ($urandom_range(0, 1) == 1) span = -span;
          end
          step_minutes(span);
        end else begin
          // tick counts kept to about a hundred minutes per transaction
          if (period_now >= 512 && $urandom_range(0, 3) == 0) begin
            amount = $urandom_range(0, 65535);
          end else begin
            hi = period_now * 100;
            if (hi > 65535) hi = 65535;
            amount = $urandom_range(0, hi);
          end
          tick_clock((kind < 78) ? REQ_TICK_FWD : REQ_TICK_BACK, amount);
        end
      end
    end

    // drain and settle
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_total == 0 && due_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
